### hdl/smen_pkg.sv
`timescale 1ns / 1ps

package smen_pkg;

  // Fixed field widths
  localparam int RANK_W  = 18;
  localparam int TAG_W   = 8;
  localparam int WIFE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int CFG_A_W = 2;
  localparam int PEOPLE_DEF = 3;

  // At most this many stable matchings are reported per job
  localparam logic [IDX_W-1:0] MAX_SOLUTIONS = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_MAN_RANKS   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WOMAN_RANKS = 2'd1;

  // Microprogram step addresses
  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_SCAN = 2'd1;
  localparam logic [1:0] STEP_TERM = 2'd2;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_MORE
  } cond_e;

  // One control word
  typedef struct packed {
    logic       load_job;
    logic       scan;
    logic       term;
    cond_e      cond;
    logic [1:0] target;
  } ctrl_t;

  // Datapath actions for the current cycle
  typedef struct packed {
    logic load_job;
    logic scan;
    logic term;
  } act_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic last_cand;
  } stat_t;

  // Control store: idle waits for a start, scan walks the candidates one per
  // cycle and falls through to the terminator after the last one.
  function automatic ctrl_t ucode(input logic [1:0] step);
    ctrl_t w;
    w = '{load_job: 1'b0, scan: 1'b0, term: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.load_job = 1'b1;
        w.cond     = COND_NO_START;
        w.target   = STEP_IDLE;
      end
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_SCAN;
      end
      STEP_TERM: begin
        w.term   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hdl/stable_matching_enumerator_core.sv
`timescale 1ns / 1ps

// Brute-force stable matching enumerator. A start is taken while busy is
// low; the job then scans all PEOPLE**PEOPLE wife assignments, one per clock in
// the scan step of the microcoded sequencer, and strobes result_valid_o for one
// cycle per stable matching (at most six) and once more for the terminator with
// last_of_job_o set. A candidate's result appears in the cycle right after it
// is scanned. From one accept to the next, the job passes through the scan of
// every candidate, the terminator step, the terminator strobe and the idle step
// in which the next start is taken. Results cannot be held off by the receiver
// and must be taken in the cycle they are shown. The user must write rank
// tables through the cfg channel only while busy is low; the block itself does
// not enforce this. Tables written so apply from the next job.
module stable_matching_enumerator_core import smen_pkg::*; #(
  parameter int PEOPLE = PEOPLE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [TAG_W-1:0]   job_tag_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [RANK_W-1:0]  cfg_data_i,
  output logic               result_valid_o,
  output logic [WIFE_W-1:0]  wife_of_man_zero_o,
  output logic [WIFE_W-1:0]  wife_of_man_one_o,
  output logic [WIFE_W-1:0]  wife_of_man_two_o,
  output logic [IDX_W-1:0]   solution_index_o,
  output logic               is_solution_o,
  output logic               last_of_job_o,
  output logic [TAG_W-1:0]   echoed_tag_o
);

  act_t  act;
  stat_t stat;
  logic  running, accept;

  assign accept      = start & ~busy;
  assign busy        = running | result_valid_o;
  assign cfg_ready_o = 1'b1;

  smen_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .stat_i   (stat),
    .act_o    (act),
    .running_o(running)
  );

  smen_datapath #(.PEOPLE(PEOPLE)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .act_i             (act),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .job_tag_i         (job_tag_i),
    .result_valid_o    (result_valid_o),
    .wife_of_man_zero_o(wife_of_man_zero_o),
    .wife_of_man_one_o (wife_of_man_one_o),
    .wife_of_man_two_o (wife_of_man_two_o),
    .solution_index_o  (solution_index_o),
    .is_solution_o     (is_solution_o),
    .last_of_job_o     (last_of_job_o),
    .echoed_tag_o      (echoed_tag_o)
  );

  // A result strobe always falls inside a busy window
  a_result_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a job");

  // The terminator never claims to be a solution
  a_term_not_sol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_job_o) |-> !is_solution_o)
    else $error("terminator marked as solution");

  // Solutions count from one
  a_sol_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_solution_o) |-> (solution_index_o != '0))
    else $error("solution with index zero");

  // An accepted start opens a job on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !result_valid_o))
    else $error("job did not start");

endmodule

### hdl/smen_check.sv
`timescale 1ns / 1ps

module smen_check import smen_pkg::*; #(
  parameter int PEOPLE = PEOPLE_DEF
) (
  input  logic [PEOPLE-1:0][WIFE_W-1:0] wife_i,
  input  logic [RANK_W-1:0]             man_ranks_i,
  input  logic [RANK_W-1:0]             woman_ranks_i,
  output logic                          perm_o,
  output logic                          stable_o
);

  // 2-bit rank at bit 2*(PEOPLE*who+whom); entries past the table read as 0
  function automatic logic [1:0] rank_of(input logic [RANK_W-1:0] tbl,
                                         input int unsigned who,
                                         input int unsigned whom);
    int unsigned sh;
    sh = 2 * (PEOPLE * who + whom);
    if (sh >= RANK_W) return 2'd0;
    return tbl[sh +: 2];
  endfunction

  logic [PEOPLE-1:0]                    seen;
  logic [PEOPLE-1:0][WIFE_W-1:0]        husband;
  logic                                 blocked;

  // Permutation test and husband table
  always_comb begin
    seen    = '0;
    perm_o  = 1'b1;
    husband = '0;
    for (int m = 0; m < PEOPLE; m++) begin
      if (seen[wife_i[m]]) perm_o = 1'b0;
      seen[wife_i[m]]    = 1'b1;
      husband[wife_i[m]] = WIFE_W'(m);
    end
  end

  // Blocking pair search over all man/woman pairs in parallel
  always_comb begin
    blocked = 1'b0;
    for (int m = 0; m < PEOPLE; m++) begin
      for (int w = 0; w < PEOPLE; w++) begin
        if (wife_i[m] != WIFE_W'(w)) begin
          if ((rank_of(man_ranks_i, m, w) < rank_of(man_ranks_i, m, 32'(wife_i[m]))) &&
              (rank_of(woman_ranks_i, w, m) <
               rank_of(woman_ranks_i, w, 32'(husband[w]))))
            blocked = 1'b1;
        end
      end
    end
    stable_o = ~blocked;
  end

endmodule

### hdl/smen_seq.sv
`timescale 1ns / 1ps

module smen_seq import smen_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  stat_t stat_i,
  output act_t  act_o,
  output logic  running_o
);

  logic [1:0] pc_q, pc_d;
  ctrl_t      word;
  logic       taken;

  // Fetch and branch resolution
  always_comb begin
    word = ucode(pc_q);
    unique case (word.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_START: taken = ~accept_i;
      COND_MORE:     taken = ~stat_i.last_cand;
      default:       taken = 1'b1;
    endcase
    pc_d = taken ? word.target : pc_q + 2'd1;
  end

  // Action strobes; the job load only fires on an accepted start
  assign act_o.load_job = word.load_job & accept_i;
  assign act_o.scan     = word.scan;
  assign act_o.term     = word.term;
  assign running_o      = (pc_q != STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hdl/smen_datapath.sv
`timescale 1ns / 1ps

module smen_datapath import smen_pkg::*; #(
  parameter int PEOPLE = PEOPLE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  act_t               act_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [RANK_W-1:0]  cfg_data_i,
  input  logic [TAG_W-1:0]   job_tag_i,
  output logic               result_valid_o,
  output logic [WIFE_W-1:0]  wife_of_man_zero_o,
  output logic [WIFE_W-1:0]  wife_of_man_one_o,
  output logic [WIFE_W-1:0]  wife_of_man_two_o,
  output logic [IDX_W-1:0]   solution_index_o,
  output logic               is_solution_o,
  output logic               last_of_job_o,
  output logic [TAG_W-1:0]   echoed_tag_o
);

  localparam logic [WIFE_W-1:0] TOP_DIGIT = WIFE_W'(PEOPLE - 1);

  logic [RANK_W-1:0]             man_q, woman_q;
  logic [TAG_W-1:0]              tag_q;
  logic [IDX_W-1:0]              count_q;
  logic [PEOPLE-1:0][WIFE_W-1:0] wife_q, wife_inc;
  logic                          perm, stable, hit, carry;
  logic [2:0][WIFE_W-1:0]        wife_sel;
  logic                          valid_q;
  logic [2:0][WIFE_W-1:0]        wife_out_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          sol_q, last_q;
  logic [TAG_W-1:0]              otag_q;

  smen_check #(.PEOPLE(PEOPLE)) u_check (
    .wife_i       (wife_q),
    .man_ranks_i  (man_q),
    .woman_ranks_i(woman_q),
    .perm_o       (perm),
    .stable_o     (stable)
  );

  // Odometer step: last man is the least significant digit
  always_comb begin
    wife_inc = wife_q;
    carry    = 1'b1;
    stat_o.last_cand = 1'b1;
    for (int i = PEOPLE - 1; i >= 0; i--) begin
      if (wife_q[i] != TOP_DIGIT) stat_o.last_cand = 1'b0;
      if (carry) begin
        if (wife_q[i] == TOP_DIGIT) begin
          wife_inc[i] = '0;
        end else begin
          wife_inc[i] = wife_q[i] + WIFE_W'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  assign hit = act_i.scan & perm & stable & (count_q < MAX_SOLUTIONS);

  // Wife fields for the three output men; absent men read as 0
  for (genvar j = 0; j < 3; j++) begin : g_sel
    if (j < PEOPLE) begin : g_man
      assign wife_sel[j] = wife_q[j];
    end else begin : g_none
      assign wife_sel[j] = '0;
    end
  end

  // Rank tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      man_q   <= '0;
      woman_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAN_RANKS)   man_q   <= cfg_data_i;
      if (cfg_index_i == REG_WOMAN_RANKS) woman_q <= cfg_data_i;
    end
  end

  // Job state: tag, found count, candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      count_q <= '0;
      wife_q  <= '0;
    end else begin
      if (act_i.load_job) begin
        tag_q   <= job_tag_i;
        count_q <= '0;
        wife_q  <= '0;
      end
      if (act_i.scan) begin
        wife_q <= wife_inc;
        if (hit) count_q <= count_q + IDX_W'(1);
      end
    end
  end

  // Result register, one strobe cycle per result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= hit | act_i.term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      wife_out_q <= wife_sel;
      idx_q      <= count_q + IDX_W'(1);
      sol_q      <= 1'b1;
      last_q     <= 1'b0;
      otag_q     <= tag_q;
    end else if (act_i.term) begin
      wife_out_q <= '0;
      idx_q      <= count_q;
      sol_q      <= 1'b0;
      last_q     <= 1'b1;
      otag_q     <= tag_q;
    end
  end

  assign result_valid_o     = valid_q;
  assign wife_of_man_zero_o = wife_out_q[0];
  assign wife_of_man_one_o  = wife_out_q[1];
  assign wife_of_man_two_o  = wife_out_q[2];
  assign solution_index_o   = idx_q;
  assign is_solution_o      = sol_q;
  assign last_of_job_o      = last_q;
  assign echoed_tag_o       = otag_q;

endmodule

### tb/smen_checker.sv
`timescale 1ns / 1ps

module smen_checker import smen_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [TAG_W-1:0]   job_tag_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [RANK_W-1:0]  cfg_data_i,
  input  logic               result_valid_i,
  input  logic [WIFE_W-1:0]  wife_of_man_zero_i,
  input  logic [WIFE_W-1:0]  wife_of_man_one_i,
  input  logic [WIFE_W-1:0]  wife_of_man_two_i,
  input  logic [IDX_W-1:0]   solution_index_i,
  input  logic               is_solution_i,
  input  logic               last_of_job_i,
  input  logic [TAG_W-1:0]   echoed_tag_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int MEN = PEOPLE_DEF;

  // One reported matching or terminator
  typedef struct packed {
    logic [WIFE_W-1:0] w0;
    logic [WIFE_W-1:0] w1;
    logic [WIFE_W-1:0] w2;
    logic [IDX_W-1:0]  idx;
    logic              sol;
    logic              last;
    logic [TAG_W-1:0]  tag;
  } matching_t;

  matching_t         expected_matchings[$];
  matching_t         head;
  logic [RANK_W-1:0] man_tab;
  logic [RANK_W-1:0] woman_tab;
  int                mismatches = 0;

  function automatic logic [1:0] rank_in(logic [RANK_W-1:0] tab, int who, int whom);
    return tab[2*(MEN*who+whom) +: 2];
  endfunction

  // Walk all wife assignments in lexicographic order, queue the stable ones
  // (capped) and then the terminator.
  function automatic void predict_matchings(logic [TAG_W-1:0] tag);
    logic [1:0]       wife    [MEN];
    logic [1:0]       husband [MEN];
    logic [MEN-1:0]   seen;
    logic [IDX_W-1:0] found;
    logic             ok;
    int               rest;
    matching_t        rec;
    found = '0;
    for (int code = 0; code < MEN * MEN * MEN; code++) begin
      rest = code;
      for (int i = MEN - 1; i >= 0; i--) begin
        wife[i] = 2'(rest % MEN);
        rest    = rest / MEN;
      end
      // one-to-one check
      ok   = 1'b1;
      seen = '0;
      for (int m = 0; m < MEN; m++) begin
        if (seen[wife[m]]) ok = 1'b0;
        seen[wife[m]]    = 1'b1;
        husband[wife[m]] = 2'(m);
      end
      // blocking pair: both sides strictly better off
      if (ok) begin
        for (int m = 0; m < MEN; m++) begin
          for (int w = 0; w < MEN; w++) begin
            if (wife[m] != w &&
                rank_in(man_tab, m, w) < rank_in(man_tab, m, int'(wife[m])) &&
                rank_in(woman_tab, w, m) < rank_in(woman_tab, w, int'(husband[w])))
              ok = 1'b0;
          end
        end
      end
      if (ok && found < MAX_SOLUTIONS) begin
        found++;
        rec = '{w0: wife[0], w1: wife[1], w2: wife[2], idx: found,
                sol: 1'b1, last: 1'b0, tag: tag};
        expected_matchings.push_back(rec);
      end
    end
    rec = '{w0: '0, w1: '0, w2: '0, idx: found, sol: 1'b0, last: 1'b1, tag: tag};
    expected_matchings.push_back(rec);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_matchings.delete();
      man_tab   = '0;
      woman_tab = '0;
    end else begin
      // result transfer against the oldest expectation
      if (result_valid_i) begin
        if (expected_matchings.size() == 0) begin
          $error("result with no job pending, tag %0d", echoed_tag_i);
          mismatches++;
        end else begin
          head = expected_matchings.pop_front();
          check_field("wife_of_man_zero", 32'(head.w0), 32'(wife_of_man_zero_i));
          check_field("wife_of_man_one", 32'(head.w1), 32'(wife_of_man_one_i));
          check_field("wife_of_man_two", 32'(head.w2), 32'(wife_of_man_two_i));
          check_field("solution_index", 32'(head.idx), 32'(solution_index_i));
          check_field("is_solution", 32'(head.sol), 32'(is_solution_i));
          check_field("last_of_job", 32'(head.last), 32'(last_of_job_i));
          check_field("echoed_tag", 32'(head.tag), 32'(echoed_tag_i));
        end
      end
      // job transfer uses the tables in force before this edge
      if (start_i && !busy_i) predict_matchings(job_tag_i);
      // register transfer
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAN_RANKS:   man_tab   = cfg_data_i;
          REG_WOMAN_RANKS: woman_tab = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_matchings.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import smen_pkg::*;

  // Indexes past the rank tables; writes there are dropped
  localparam logic [CFG_A_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int PHASES     = 12;
  localparam int PHASE_JOBS = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [TAG_W-1:0]   job_tag_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_A_W-1:0] cfg_index_i;
  logic [RANK_W-1:0]  cfg_data_i;
  logic               result_valid_o;
  logic [WIFE_W-1:0]  wife_of_man_zero_o;
  logic [WIFE_W-1:0]  wife_of_man_one_o;
  logic [WIFE_W-1:0]  wife_of_man_two_o;
  logic [IDX_W-1:0]   solution_index_o;
  logic               is_solution_o;
  logic               last_of_job_o;
  logic [TAG_W-1:0]   echoed_tag_o;
  int                 fail_count;
  int                 pending;

  always #4 clk_i = ~clk_i;

  stable_matching_enumerator_core uut (
    .clk_i, .rst_ni, .start, .busy, .job_tag_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .wife_of_man_zero_o, .wife_of_man_one_o, .wife_of_man_two_o,
    .solution_index_o, .is_solution_o, .last_of_job_o, .echoed_tag_o
  );

  smen_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .job_tag_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o),
    .wife_of_man_zero_i(wife_of_man_zero_o), .wife_of_man_one_i(wife_of_man_one_o),
    .wife_of_man_two_i(wife_of_man_two_o), .solution_index_i(solution_index_o),
    .is_solution_i(is_solution_o), .last_of_job_i(last_of_job_o),
    .echoed_tag_i(echoed_tag_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Well-formed table: each person ranks the other side 0..2 in random order
  function automatic logic [RANK_W-1:0] perm_table();
    logic [RANK_W-1:0] tab;
    int r0, r1;
    tab = '0;
    for (int p = 0; p < PEOPLE_DEF; p++) begin
      r0 = $urandom_range(0, 2);
      r1 = (r0 + $urandom_range(1, 2)) % 3;
      tab[2*(3*p+0) +: 2] = 2'(r0);
      tab[2*(3*p+1) +: 2] = 2'(r1);
      tab[2*(3*p+2) +: 2] = 2'(3 - r0 - r1);
    end
    return tab;
  endfunction

  // Rotated preferences, person p ranks k at (k - p + shift) mod 3
  function automatic logic [RANK_W-1:0] cyclic_table(int shift);
    logic [RANK_W-1:0] tab;
    tab = '0;
    for (int p = 0; p < PEOPLE_DEF; p++)
      for (int k = 0; k < PEOPLE_DEF; k++)
        tab[2*(3*p+k) +: 2] = 2'((k + 3 - p + shift) % 3);
    return tab;
  endfunction

  // Random raw table, rank three included
  function automatic logic [RANK_W-1:0] raw_table();
    return RANK_W'($urandom_range(0, 18'h3FFFF));
  endfunction

  // Random job tag
  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [RANK_W-1:0] val);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Start stays high across back-to-back jobs when the drawn gap is zero
  task automatic run_job(logic [TAG_W-1:0] tag);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    job_tag_i <= tag;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait for every queued result and for the block to go idle
  task automatic settle(int limit);
    int n;
    n = 0;
    @(negedge clk_i);
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
    end while ((pending != 0 || busy) && n < limit);
  endtask

  task automatic load_tables(logic [RANK_W-1:0] men, logic [RANK_W-1:0] women);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_MAN_RANKS, men);
      write_reg(REG_WOMAN_RANKS, women);
    end else begin
      write_reg(REG_WOMAN_RANKS, women);
      write_reg(REG_MAN_RANKS, men);
    end
  endtask

  initial begin
    int kind;
    logic [RANK_W-1:0] men, women;
    start       = 1'b0;
    job_tag_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MAN_RANKS;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all ranks tied at zero: every permutation is stable, cap reached
    load_tables('0, '0);
    run_job(8'h00);
    run_job(8'hFF);
    settle(1000);
    // all ranks tied at three
    load_tables('1, '1);
    run_job(8'hAA);
    run_job(8'h55);
    settle(1000);
    // same rotation on both sides, then rotations shifted by one against each other
    load_tables(cyclic_table(0), cyclic_table(0));
    run_job(rand_tag());
    settle(1000);
    load_tables(cyclic_table(0), cyclic_table(1));
    run_job(rand_tag());
    run_job(rand_tag());
    settle(1000);
    // strict men against indifferent women
    load_tables(perm_table(), '0);
    run_job(rand_tag());
    settle(1000);
    // raw tables with rank three mixed in; spare indexes must be ignored
    load_tables(raw_table(), raw_table());
    write_reg(REG_SPARE_LO, raw_table());
    write_reg(REG_SPARE_HI, raw_table());
    run_job(rand_tag());
    run_job(rand_tag());
    run_job(rand_tag());
    settle(1000);

    // random phases, mostly well-formed preference tables
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          men   = perm_table();
          women = perm_table();
        end
        6: begin
          men   = raw_table();
          women = raw_table();
        end
        7: begin
          men   = perm_table();
          women = perm_table() | RANK_W'($urandom & $urandom);
        end
        8: begin
          men   = $urandom_range(0, 1) ? '1 : '0;
          women = perm_table();
        end
        default: begin
          men   = perm_table() | RANK_W'($urandom & $urandom);
          women = perm_table();
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, raw_table());
      load_tables(men, women);
      for (int j = 0; j < PHASE_JOBS; j++)
        run_job(rand_tag());
      settle(1000);
    end

    settle(4000);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("** stable_matching_enumerator_core: PASSED **");
    else
      $display("** stable_matching_enumerator_core: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** stable_matching_enumerator_core: FAILED **");
    $finish;
  end

endmodule
